// ===== sv/utf8_stream_validator_macros.svh =====
// Assertion macros for the UTF-8 stream validator.
// Included by the top level; define NO_ASSERTIONS to compile them away.
`ifndef UTF8_STREAM_VALIDATOR_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge outside reset.
`define UTF8V_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define UTF8V_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define UTF8V_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define UTF8V_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/utf8v_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the UTF-8 stream validator.
// No dependencies; used by every module of the block.
package utf8v_pkg;

	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 16;
	localparam int COUNT_W = 17;
	localparam int CP_W    = 21;

	localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 16'd256;

	localparam logic [CP_W-1:0] CP_MIN_3BYTE  = 21'h000800;
	localparam logic [CP_W-1:0] CP_MIN_4BYTE  = 21'h010000;
	localparam logic [CP_W-1:0] CP_MAX        = 21'h10FFFF;
	localparam logic [CP_W-1:0] CP_SURR_LOW   = 21'h00D800;
	localparam logic [CP_W-1:0] CP_SURR_HIGH  = 21'h00DFFF;

	// Continuation counts of a sequence, by lead byte class.
	localparam logic [1:0] SEQ_NONE  = 2'd0;
	localparam logic [1:0] SEQ_TWO   = 2'd1;
	localparam logic [1:0] SEQ_THREE = 2'd2;
	localparam logic [1:0] SEQ_FOUR  = 2'd3;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
		logic              last;
	} utf8v_item_t;

	typedef struct packed {
		logic               string_valid;
		logic [COUNT_W-1:0] byte_count;
	} utf8v_result_t;

endpackage

// ===== sv/utf8v_in_stage.sv =====
`timescale 1ns / 1ps
// Input register of the UTF-8 stream validator.
// Depends on utf8v_pkg.
module utf8v_in_stage (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [utf8v_pkg::BYTE_W-1:0] data_byte,
	input  logic                         last_byte,
	input  logic                         advance,
	output utf8v_pkg::utf8v_item_t       item_s1
);
	import utf8v_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              last_s1;

	// The held byte only blocks when it cannot move on this cycle.
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	assign item_s1 = '{valid: valid_s1, data: data_s1, last: last_s1};

endmodule

// ===== sv/utf8v_decoder.sv =====
`timescale 1ns / 1ps
// Per-string decode state, byte decoder and verdict logic of the validator.
// Depends on utf8v_pkg.
module utf8v_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [utf8v_pkg::LEN_W-1:0] cfg_wr_data,
	input  utf8v_pkg::utf8v_item_t      item_s1,
	input  logic                        step,
	output utf8v_pkg::utf8v_result_t    result
);
	import utf8v_pkg::*;

	logic [LEN_W-1:0]   max_length_q;
	logic [1:0]         pend_q;
	logic [1:0]         seq_q;
	logic [CP_W-1:0]    cp_q;
	logic               err_q;
	logic [COUNT_W-1:0] bytes_q;

	logic [1:0]         pend_n;
	logic [1:0]         seq_n;
	logic [CP_W-1:0]    cp_n;
	logic               err_n;
	logic [COUNT_W-1:0] bytes_n;
	logic [CP_W-1:0]    cp_shift;
	logic [BYTE_W-1:0]  b;

	assign b        = item_s1.data;
	assign cp_shift = {cp_q[CP_W-7:0], b[5:0]};

	always_comb begin
		pend_n  = pend_q;
		seq_n   = seq_q;
		cp_n    = cp_q;
		err_n   = err_q;
		// The count saturates once it reaches 65536.
		bytes_n = bytes_q[COUNT_W-1] ? bytes_q : bytes_q + 17'd1;
		if (!err_q) begin
			if (pend_q == 2'd0) begin
				unique case (b) inside
					8'h00: err_n = 1'b1;
					[8'h01:8'h7F]: ;
					[8'hC2:8'hDF]: begin
						cp_n   = {16'd0, b[4:0]};
						pend_n = SEQ_TWO;
						seq_n  = SEQ_TWO;
					end
					[8'hE0:8'hEF]: begin
						cp_n   = {17'd0, b[3:0]};
						pend_n = SEQ_THREE;
						seq_n  = SEQ_THREE;
					end
					[8'hF0:8'hF7]: begin
						cp_n   = {18'd0, b[2:0]};
						pend_n = SEQ_FOUR;
						seq_n  = SEQ_FOUR;
					end
					default: err_n = 1'b1;
				endcase
			end else if (b[7:6] != 2'b10) begin
				err_n = 1'b1;
			end else begin
				pend_n = pend_q - 2'd1;
				cp_n   = cp_shift;
				if (pend_q == 2'd1) begin
					// Sequence complete: reject overlong forms, surrogates and
					// code points beyond the Unicode range.
					if ((seq_q == SEQ_THREE && cp_shift < CP_MIN_3BYTE) ||
					    (seq_q == SEQ_FOUR && cp_shift < CP_MIN_4BYTE) ||
					    cp_shift > CP_MAX ||
					    (cp_shift >= CP_SURR_LOW && cp_shift <= CP_SURR_HIGH)) begin
						err_n = 1'b1;
					end
					seq_n = SEQ_NONE;
					cp_n  = '0;
				end
			end
		end
	end

	assign result.string_valid = !err_n && pend_n == 2'd0 &&
	                             bytes_n <= {1'b0, max_length_q};
	assign result.byte_count   = bytes_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RESET;
			pend_q       <= '0;
			seq_q        <= SEQ_NONE;
			cp_q         <= '0;
			err_q        <= 1'b0;
			bytes_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				max_length_q <= cfg_wr_data;
			end
			if (step) begin
				if (item_s1.last) begin
					pend_q  <= '0;
					seq_q   <= SEQ_NONE;
					cp_q    <= '0;
					err_q   <= 1'b0;
					bytes_q <= '0;
				end else begin
					pend_q  <= pend_n;
					seq_q   <= seq_n;
					cp_q    <= cp_n;
					err_q   <= err_n;
					bytes_q <= bytes_n;
				end
			end
		end
	end

endmodule

// ===== sv/utf8v_out_reg.sv =====
`timescale 1ns / 1ps
// Result register of the validator; holds one verdict until the receiver takes it.
// Depends on utf8v_pkg.
module utf8v_out_reg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  utf8v_pkg::utf8v_result_t      result,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          full_stalled,
	output logic                          string_valid,
	output logic [utf8v_pkg::COUNT_W-1:0] byte_count
);
	import utf8v_pkg::*;

	logic          out_valid_q;
	utf8v_result_t data_q;

	assign full_stalled = out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign string_valid = data_q.string_valid;
	assign byte_count   = data_q.byte_count;

endmodule

// ===== sv/utf8_stream_validator.sv =====
`timescale 1ns / 1ps
// UTF-8 stream validator, top level.
// Depends on utf8v_pkg, utf8v_in_stage, utf8v_decoder, utf8v_out_reg and the macros header.
//
// Usage: a string is presented one byte per request on the input channel
// (in_valid, in_stall, data_byte, last_byte), with last_byte set on its final
// byte. When the final byte has been decoded, one request leaves on the output
// channel (out_valid, out_stall, string_valid, byte_count): string_valid is 1
// for strict UTF-8 with no NUL and no more than max_length bytes, and
// byte_count gives the string length, saturating at 65536. Other bytes give
// no output.
// Throughput is one byte per cycle while in_stall is low. A byte is held in
// the input register and is decoded there against the per-string state; a
// final byte then loads the result register, which drives out_valid.
// While the receiver stalls a waiting result, bytes that are not final keep
// flowing; a final byte waits in the input register and in_stall rises until
// the result register is free. Reset clears all string state and both
// registers and sets max_length to 256. max_length is written through cfg_wr_en
// and cfg_wr_data, by the user only while idle; the block does not enforce it.
`include "utf8_stream_validator_macros.svh"
module utf8_stream_validator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [utf8v_pkg::LEN_W-1:0]   cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [utf8v_pkg::BYTE_W-1:0]  data_byte,
	input  logic                          last_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          string_valid,
	output logic [utf8v_pkg::COUNT_W-1:0] byte_count
);
	import utf8v_pkg::*;

	utf8v_item_t   item_s1;
	utf8v_result_t result;
	logic          full_stalled;
	logic          advance;
	logic          step;
	logic          push;

	// Only a final byte needs room in the result register.
	assign advance = !(item_s1.last && full_stalled);
	assign step    = item_s1.valid && advance;
	assign push    = step && item_s1.last;

	utf8v_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.advance   (advance),
		.item_s1   (item_s1)
	);

	utf8v_decoder u_decoder (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item_s1     (item_s1),
		.step        (step),
		.result      (result)
	);

	utf8v_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.result       (result),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.full_stalled (full_stalled),
		.string_valid (string_valid),
		.byte_count   (byte_count)
	);

	`UTF8V_ASSERT_IMPL(a_stall_cause, clk, arst_n, in_stall, item_s1.valid && item_s1.last && out_valid && out_stall, "input stalled without a blocked result")
	`UTF8V_ASSERT_NEXT(a_push_shows, clk, arst_n, push, out_valid && byte_count != '0, "final byte did not produce a result")
	`UTF8V_ASSERT_IMPL(a_count_nonzero, clk, arst_n, out_valid, byte_count != '0, "result with zero byte count")

endmodule
